[src/kare_pkg.sv]
// kare_pkg: shared types and constants for the key auto repeat engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kare_pkg;

    localparam int KEY_W    = 6;
    localparam int KST_W    = 2;
    localparam int EVS_W    = 3;
    localparam int IVL_W    = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [KST_W-1:0] KST_HOLD     = 2'd2;
    localparam logic [KST_W-1:0] KST_RELEASED = 2'd3;
    localparam logic [EVS_W-1:0] EVT_AUTOREPEAT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_INTERVAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DELAY      = 2'd2;

    localparam logic [IVL_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_HOLD,
        CMD_RELEASE,
        CMD_ECHO
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [KEY_W-1:0] key;
        logic [KST_W-1:0] kst;
    } kare_item_t;

    typedef struct packed {
        logic       valid;
        kare_item_t item;
    } kare_link_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [IVL_W-1:0]     data;
    } kare_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

endpackage

`default_nettype wire

[src/kare_front.sv]
// kare_front: takes requests on the start/busy handshake and classifies them.
// Depends on kare_pkg; feeds kare_queue.
`timescale 1ns / 1ps
`default_nettype none

module kare_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       req_type,
    input  wire logic [kare_pkg::KEY_W-1:0] key_code,
    input  wire logic [kare_pkg::KST_W-1:0] key_state,
    input  wire logic                       q_full,
    output kare_pkg::kare_link_t            push
);
    import kare_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    kare_item_t item_reg;
    cmd_op_t    op;
    logic       accept;

    always_comb
    begin
        if (!req_type)
            op = CMD_TICK;
        else if (key_state == KST_HOLD)
            op = CMD_HOLD;
        else if (key_state == KST_RELEASED)
            op = CMD_RELEASE;
        else
            op = CMD_ECHO;
    end

    assign busy       = valid_reg & q_full;
    assign accept     = start & ~busy;
    assign valid_next = accept | (valid_reg & q_full);

    assign push.valid = valid_reg & ~q_full;
    assign push.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= '{op: op, key: key_code, kst: key_state};
    end

endmodule

`default_nettype wire

[src/kare_queue.sv]
// kare_queue: short request queue between the front and back parts.
// Depends on kare_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kare_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kare_pkg::kare_link_t push,
    output logic                      full,
    output kare_pkg::kare_link_t      head,
    input  wire logic                 pop
);
    import kare_pkg::*;

    kare_item_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push.valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.item;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/kare_back.sv]
// kare_back: configuration registers, repeat table, tick scan and result register.
// Depends on kare_pkg; pops requests from kare_queue.
`timescale 1ns / 1ps
`default_nettype none

module kare_back #(
    parameter int TABLE_SLOTS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire kare_pkg::kare_cfg_t         cfg,
    input  wire kare_pkg::kare_link_t        head,
    output logic                             pop,
    output logic                             event_valid,
    output logic [kare_pkg::KEY_W-1:0]       event_key,
    output logic [kare_pkg::EVS_W-1:0]       event_state,
    output logic                             last
);
    import kare_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    back_state_t state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] now_ms_reg;
    logic [IVL_W-1:0]  rep_reg, fast_reg, delay_reg;

    logic [KEY_W-1:0]  key_reg   [TABLE_SLOTS];
    logic [TIME_W-1:0] stamp_reg [TABLE_SLOTS];
    logic [IVL_W-1:0]  count_reg [TABLE_SLOTS];

    logic              pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [KEY_W-1:0]  ev_key_reg, ev_key_next;
    logic [EVS_W-1:0]  ev_state_reg, ev_state_next;
    logic              ev_last_reg, ev_last_next;

    logic              free_found, match_found;
    logic [IDX_W-1:0]  free_idx, match_idx;
    logic              do_arm, do_free, fire, slow;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_stamp, elapsed;
    logic [IVL_W-1:0]  rd_count;
    logic              rep_on;

    assign rep_on   = (rep_reg != '0);
    assign pop      = (state_reg == ST_IDLE) & head.valid;
    assign rd_key   = key_reg[idx_reg];
    assign rd_stamp = stamp_reg[idx_reg];
    assign rd_count = count_reg[idx_reg];
    assign elapsed  = now_ms_reg - rd_stamp;
    assign slow     = (delay_reg == '0) || (rd_count < delay_reg);

    always_comb
    begin
        if (rd_key == '0)
            fire = 1'b0;
        else if (slow)
            fire = elapsed > {{(TIME_W-IVL_W){1'b0}}, rep_reg};
        else
            fire = (fast_reg != '0) && (elapsed > {{(TIME_W-IVL_W){1'b0}}, fast_reg});
    end

    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (key_reg[i] == '0)
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (key_reg[i] == head.item.key)
            begin
                match_found = 1'b1;
                match_idx   = IDX_W'(i);
            end
        end
    end

    assign do_arm  = pop && rep_on && (head.item.op == CMD_HOLD)
                     && (head.item.key != '0) && free_found;
    assign do_free = pop && rep_on && (head.item.op == CMD_RELEASE)
                     && (head.item.key != '0) && match_found;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.item.op == CMD_TICK && rep_on)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_LAST)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ev_valid_next   = 1'b0;
        ev_key_next     = ev_key_reg;
        ev_state_next   = ev_state_reg;
        ev_last_next    = ev_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pend_valid_next = 1'b0;
                if (pop && head.item.op != CMD_TICK)
                begin
                    ev_valid_next = 1'b1;
                    ev_key_next   = head.item.key;
                    ev_state_next = {1'b0, head.item.kst};
                    ev_last_next  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (fire)
                begin
                    if (pend_valid_reg)
                    begin
                        ev_valid_next = 1'b1;
                        ev_key_next   = pend_key_reg;
                        ev_state_next = EVT_AUTOREPEAT;
                        ev_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_key_next   = rd_key;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    ev_valid_next = 1'b1;
                    ev_key_next   = pend_key_reg;
                    ev_state_next = EVT_AUTOREPEAT;
                    ev_last_next  = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
                pend_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            now_ms_reg     <= '0;
            rep_reg        <= '0;
            fast_reg       <= '0;
            delay_reg      <= '0;
            pend_valid_reg <= 1'b0;
            ev_valid_reg   <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= (state_reg == ST_SCAN && idx_reg != IDX_LAST) ?
                              idx_reg + 1'b1 : '0;
            pend_valid_reg <= pend_valid_next;
            ev_valid_reg   <= ev_valid_next;
            if (pop && head.item.op == CMD_TICK)
                now_ms_reg <= now_ms_reg + 1'b1;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_REPEAT_INTERVAL: rep_reg   <= cfg.data;
                    CFG_FAST_INTERVAL:   fast_reg  <= cfg.data;
                    CFG_FAST_DELAY:      delay_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (cfg.valid && cfg.index == CFG_REPEAT_INTERVAL)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    key_reg[i] <= '0;
            end
            else if (do_arm)
                key_reg[free_idx] <= head.item.key;
            else if (do_free)
                key_reg[match_idx] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_key_reg <= pend_key_next;
        ev_key_reg   <= ev_key_next;
        ev_state_reg <= ev_state_next;
        ev_last_reg  <= ev_last_next;
        if (do_arm)
        begin
            stamp_reg[free_idx] <= now_ms_reg + {{(TIME_W-IVL_W){1'b0}}, rep_reg};
            count_reg[free_idx] <= '0;
        end
        else if (state_reg == ST_SCAN && fire)
        begin
            stamp_reg[idx_reg] <= now_ms_reg;
            if (fast_reg != '0 && rd_count != COUNT_MAX)
                count_reg[idx_reg] <= rd_count + 1'b1;
        end
    end

    assign event_valid = ev_valid_reg;
    assign event_key   = ev_key_reg;
    assign event_state = ev_state_reg;
    assign last        = ev_last_reg;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending repeat left after scan");
    a_repeat_key: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && ev_state_reg == EVT_AUTOREPEAT) |-> (ev_key_reg != '0))
        else $error("repeat event from free slot");
    a_not_last_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && !ev_last_reg) |-> (ev_state_reg == EVT_AUTOREPEAT))
        else $error("key change result not marked last");
    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (state_reg == ST_IDLE))
        else $error("scan did not finish");

endmodule

`default_nettype wire

[src/key_auto_repeat_engine.sv]
// An accepted key change is registered in the front, queued and popped by the back part
// into the result register (event_valid). One key change per cycle goes through the back
// part while it is idle; a tick with auto repeat on holds it for a scan of all slots (one
// table slot scanned per cycle) and a flush. Results cannot be stalled by the receiver.
// Reset (rst_n, async, active low) clears control state, configuration, time and the table keys; no clearing pass.
// Depends on kare_pkg, kare_front, kare_queue, kare_back.
`timescale 1ns / 1ps
`default_nettype none

module key_auto_repeat_engine #(
    parameter int TABLE_SLOTS = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           req_type,
    input  wire logic [kare_pkg::KEY_W-1:0]     key_code,
    input  wire logic [kare_pkg::KST_W-1:0]     key_state,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kare_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kare_pkg::IVL_W-1:0]     cfg_data,
    output logic                                event_valid,
    output logic [kare_pkg::KEY_W-1:0]          event_key,
    output logic [kare_pkg::EVS_W-1:0]          event_state,
    output logic                                last
);
    import kare_pkg::*;

    kare_link_t push;
    kare_link_t head;
    kare_cfg_t  cfg;
    logic       q_full;
    logic       pop;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid & cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    kare_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .key_code  (key_code),
        .key_state (key_state),
        .q_full    (q_full),
        .push      (push)
    );

    kare_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    kare_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .pop         (pop),
        .event_valid (event_valid),
        .event_key   (event_key),
        .event_state (event_state),
        .last        (last)
    );

endmodule

`default_nettype wire

[verif/key_auto_repeat_engine_tb.sv]
// key_auto_repeat_engine_tb: self-checking bench for the typematic auto repeat engine.
// Depends on kare_pkg and key_auto_repeat_engine; predicts every event and checks it in order.
`timescale 1ns / 1ps

module key_auto_repeat_engine_tb;

    import kare_pkg::*;

    localparam int SLOTS = 10;
    localparam int LIMIT = 400000;
    localparam int SETTLE_CYCLES = 64;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEY  = 1'b1;
    localparam logic [KST_W-1:0] KST_IDLE    = 2'd0;
    localparam logic [KST_W-1:0] KST_PRESSED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             rt;
        logic [KEY_W-1:0] key;
        logic [KST_W-1:0] kst;
    } key_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [EVS_W-1:0] st;
        logic             fin;
    } key_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 req_type = 1'b0;
    logic [KEY_W-1:0]     key_code = '0;
    logic [KST_W-1:0]     key_state = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IVL_W-1:0]     cfg_data = '0;
    logic                 event_valid;
    logic [KEY_W-1:0]     event_key;
    logic [EVS_W-1:0]     event_state;
    logic                 evt_last;

    key_auto_repeat_engine #(.TABLE_SLOTS(SLOTS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .key_code(key_code),
        .key_state(key_state),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .event_valid(event_valid),
        .event_key(event_key),
        .event_state(event_state),
        .last(evt_last)
    );

    // typematic state as the block should hold it
    logic [IVL_W-1:0]  rpt_ivl = '0;
    logic [IVL_W-1:0]  fast_ivl = '0;
    logic [IVL_W-1:0]  fast_dly = '0;
    logic [TIME_W-1:0] now_ms = '0;
    logic [KEY_W-1:0]  slot_key [SLOTS];
    logic [TIME_W-1:0] slot_stamp [SLOTS];
    logic [IVL_W-1:0]  slot_count [SLOTS];

    key_req_t   pending_reqs[$];
    key_event_t expected_events[$];

    int       n_queued = 0;
    int       n_taken = 0;
    int       cfg_writes = 0;
    int       errors = 0;
    int       cycles = 0;
    int       gap_mode = 1;
    int       gap_left = 0;
    logic     took = 1'b0;
    key_req_t next_req;
    key_event_t got;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void clear_slots();
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i] = '0;
            slot_stamp[i] = '0;
            slot_count[i] = '0;
        end
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [IVL_W-1:0] val);
        case (idx)
            CFG_REPEAT_INTERVAL:
            begin
                rpt_ivl = val;
                clear_slots();
            end
            CFG_FAST_INTERVAL: fast_ivl = val;
            CFG_FAST_DELAY:    fast_dly = val;
            default: ;
        endcase
    endfunction

    function automatic void predict_events(input key_req_t rq);
        key_event_t ev;
        logic [TIME_W-1:0] elapsed;
        logic fire;
        int n;
        n = 0;
        if (rq.rt == REQ_KEY) begin
            ev.key = rq.key;
            ev.st = {1'b0, rq.kst};
            ev.fin = 1'b1;
            expected_events.push_back(ev);
            if (rpt_ivl != 0) begin
                if (rq.kst == KST_HOLD) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_key[i] == '0) begin
                            slot_key[i] = rq.key;
                            slot_stamp[i] = now_ms + {16'd0, rpt_ivl};
                            slot_count[i] = '0;
                            break;
                        end
                    end
                end else if (rq.kst == KST_RELEASED) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_key[i] == rq.key) begin
                            slot_key[i] = '0;
                            slot_stamp[i] = '0;
                            slot_count[i] = '0;
                            break;
                        end
                    end
                end
            end
        end else begin
            now_ms = now_ms + 1;
            if (rpt_ivl != 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_key[i] != '0) begin
                        elapsed = now_ms - slot_stamp[i];
                        fire = 1'b0;
                        if (fast_dly == 0 || slot_count[i] < fast_dly)
                            fire = (elapsed > {16'd0, rpt_ivl});
                        else if (fast_ivl != 0)
                            fire = (elapsed > {16'd0, fast_ivl});
                        if (fire) begin
                            ev.key = slot_key[i];
                            ev.st = EVT_AUTOREPEAT;
                            ev.fin = 1'b0;
                            expected_events.push_back(ev);
                            n++;
                            slot_stamp[i] = now_ms;
                            if (fast_ivl != 0 && slot_count[i] != COUNT_MAX)
                                slot_count[i] = slot_count[i] + 1'b1;
                        end
                    end
                end
                if (n > 0) begin
                    ev = expected_events.pop_back();
                    ev.fin = 1'b1;
                    expected_events.push_back(ev);
                end
            end
        end
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_mode == 0 || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(negedge clk) begin
        if (!start || took) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                req_type <= next_req.rt;
                key_code <= next_req.key;
                key_state <= next_req.kst;
                start <= 1'b1;
                gap_left = idle_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // event monitor, predictor and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            cycles = cycles + 1;
            if (event_valid) begin
                if (expected_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected event key=%0d state=%0d last=%0b",
                             $time, event_key, event_state, evt_last);
                end else begin
                    got = expected_events.pop_front();
                    if (event_key !== got.key) begin
                        errors++;
                        $display("%0t: event_key expected %0d actual %0d",
                                 $time, got.key, event_key);
                    end
                    if (event_state !== got.st) begin
                        errors++;
                        $display("%0t: event_state expected %0d actual %0d",
                                 $time, got.st, event_state);
                    end
                    if (evt_last !== got.fin) begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, got.fin, evt_last);
                    end
                end
            end
            took <= start && !busy;
            if (start && !busy) begin
                predict_events('{rt: req_type, key: key_code, kst: key_state});
                n_taken <= n_taken + 1;
            end
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
                cfg_writes <= cfg_writes + 1;
            end
            if (cycles > LIMIT) begin
                $display("key_auto_repeat_engine_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic void queue_req(input logic rt, input logic [KEY_W-1:0] key,
                                      input logic [KST_W-1:0] kst);
        pending_reqs.push_back('{rt: rt, key: key, kst: kst});
        n_queued++;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        if ($urandom_range(0, 9) == 0)
            k = KEY_W'($urandom_range(0, 63));
        else
            k = KEY_W'($urandom_range(1, 6));
        return k;
    endfunction

    function automatic logic [IVL_W-1:0] pick_setting(input int zero_pct, input int lo,
                                                      input int hi);
        int r;
        logic [IVL_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            v = '0;
        else if (r < 85)
            v = IVL_W'($urandom_range(lo, hi));
        else if (r < 93)
            v = IVL_W'($urandom_range(0, 65535));
        else
            v = '1;
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IVL_W-1:0] val);
        int seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        wait (cfg_writes != seen);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // scans of ticks with no events may still run after the last event
    task automatic settle();
        wait (n_taken == n_queued && expected_events.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [IVL_W-1:0] rpt, input logic [IVL_W-1:0] fst,
                             input logic [IVL_W-1:0] dly);
        settle();
        write_reg(CFG_FAST_INTERVAL, fst);
        write_reg(CFG_FAST_DELAY, dly);
        write_reg(CFG_REPEAT_INTERVAL, rpt);
    endtask

    task automatic run_phase(input logic [IVL_W-1:0] rpt, input logic [IVL_W-1:0] fst,
                             input logic [IVL_W-1:0] dly, input int count, input int mode);
        int left;
        int run;
        int r;
        configure(rpt, fst, dly);
        gap_mode = mode;
        left = count;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                run = $urandom_range(1, 5);
                repeat (run)
                    queue_req(REQ_TICK, KEY_W'($urandom_range(0, 63)),
                              KST_W'($urandom_range(0, 3)));
                left -= run;
            end else begin
                if (r < 72)
                    queue_req(REQ_KEY, pick_key(), KST_HOLD);
                else if (r < 92)
                    queue_req(REQ_KEY, pick_key(), KST_RELEASED);
                else
                    queue_req(REQ_KEY, KEY_W'($urandom_range(0, 63)),
                              KST_W'($urandom_range(0, 3)));
                left--;
            end
        end
    endtask

    initial begin
        clear_slots();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers at reset: echoes only, ticks are silent
        queue_req(REQ_KEY, 6'd63, KST_PRESSED);
        queue_req(REQ_KEY, 6'd0, KST_IDLE);
        queue_req(REQ_KEY, 6'd5, KST_HOLD);
        queue_req(REQ_KEY, 6'd5, KST_RELEASED);
        queue_req(REQ_TICK, 6'd63, 2'd3);
        queue_req(REQ_TICK, 6'd0, 2'd0);

        configure(16'd1, 16'd0, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        queue_req(REQ_KEY, 6'd63, KST_HOLD);
        for (int k = 1; k <= 9; k++)
            queue_req(REQ_KEY, KEY_W'(k), KST_HOLD);
        queue_req(REQ_KEY, 6'd5, KST_HOLD);      // table full
        queue_req(REQ_TICK, 6'd0, 2'd0);
        queue_req(REQ_TICK, 6'd0, 2'd0);
        queue_req(REQ_TICK, 6'd0, 2'd0);         // all ten slots fire
        queue_req(REQ_KEY, 6'd63, KST_RELEASED);
        queue_req(REQ_KEY, 6'd40, KST_RELEASED); // key not held
        queue_req(REQ_KEY, 6'd0, KST_RELEASED);
        queue_req(REQ_KEY, 6'd0, KST_HOLD);
        queue_req(REQ_KEY, 6'd7, KST_HOLD);      // second slot for one key
        queue_req(REQ_TICK, 6'd0, 2'd0);

        run_phase(16'd3, 16'd1, 16'd2, 29, 1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 29, 0);
        for (int p = 0; p < 5; p++)
            run_phase(pick_setting(8, 1, 6), pick_setting(30, 1, 3), pick_setting(30, 1, 4),
                      29, (p == 2) ? 0 : 1);

        settle();
        if (errors == 0)
            $display("key_auto_repeat_engine_tb OK");
        else
            $display("key_auto_repeat_engine_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
src/kare_pkg.sv
src/kare_front.sv
src/kare_queue.sv
src/kare_back.sv
src/key_auto_repeat_engine.sv
verif/key_auto_repeat_engine_tb.sv
